### sv/drs_pkg.sv
// shared types and codes for the dual range oxygen sensor selector
// no dependencies; used by drs_sensor and the core by scoped name
package drs_pkg;

   typedef enum logic [1:0] {
      MODE_SAMPLE = 2'd0,
      MODE_ON     = 2'd1,
      MODE_OFF    = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      RS_WITHIN = 2'd0,
      RS_ABOVE  = 2'd1,
      RS_BELOW  = 2'd2
   } range_type;

   typedef enum logic [2:0] {
      REG_LOW_MIN   = 3'd0,
      REG_LOW_MAX   = 3'd1,
      REG_LOW_TRANS = 3'd2,
      REG_HIGH_MIN  = 3'd3,
      REG_HIGH_MAX  = 3'd4,
      REG_HIGH_TRAN = 3'd5,
      REG_STAB_MS   = 3'd6,
      REG_ADC_OFF   = 3'd7
   } reg_index_type;

   typedef struct packed {
      range_type rs;
      logic      stab;
      logic      trans;
   } sensor_state_type;

   localparam int CSR_BITS = 32;
   localparam int ADC_BITS = 16;
   localparam int STAB_BITS = 32;

endpackage

### sv/drs_sensor.sv
// next state of one sensor for a turn-on, turn-off or sample word
// depends on drs_pkg
module drs_sensor #(
   parameter int LEVEL_BITS = 20,
   parameter int TICK_BITS  = 32
) (
   input  logic                           low_side,
   input  logic [1:0]                     mode,
   input  logic                           selected,
   input  logic                           present,
   input  drs_pkg::sensor_state_type      cur,
   input  logic [TICK_BITS-1:0]           since_on,
   input  logic [LEVEL_BITS-1:0]          lvl,
   input  logic [drs_pkg::ADC_BITS-1:0]   adc,
   input  logic [LEVEL_BITS-1:0]          min_level,
   input  logic [LEVEL_BITS-1:0]          max_level,
   input  logic [LEVEL_BITS-1:0]          trans_level,
   input  logic [drs_pkg::STAB_BITS-1:0]  stabilize_ms,
   input  logic [drs_pkg::ADC_BITS-1:0]   adc_off_level,
   output drs_pkg::sensor_state_type      nxt
);

   logic near_edge;

   assign near_edge = low_side ? (lvl > trans_level) : (lvl < trans_level);

   always_comb begin
      nxt = cur;
      case (mode)
         drs_pkg::MODE_ON: begin
            if (selected) begin
               nxt.rs   = drs_pkg::RS_WITHIN;
               nxt.stab = 1'b0;
            end
         end
         drs_pkg::MODE_OFF: begin
            if (selected) begin
               nxt.stab  = 1'b0;
               nxt.trans = 1'b0;
            end
         end
         drs_pkg::MODE_SAMPLE: begin
            if (present) begin
               if (!cur.stab) begin
                  if (drs_pkg::STAB_BITS'(since_on) > stabilize_ms) begin
                     nxt.stab = 1'b1;
                  end
               end else if (lvl > max_level || adc >= adc_off_level) begin
                  nxt.rs    = drs_pkg::RS_ABOVE;
                  nxt.trans = low_side;
               end else if (lvl < min_level) begin
                  nxt.rs    = drs_pkg::RS_BELOW;
                  nxt.trans = !low_side;
               end else if (near_edge) begin
                  nxt.trans = 1'b1;
               end else if (lvl > min_level && lvl < max_level) begin
                  nxt.rs    = drs_pkg::RS_WITHIN;
                  nxt.trans = 1'b0;
               end
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

### sv/drs_select.sv
// picks the combined reading from the two sensors after their update
// no dependencies
module drs_select #(
   parameter int LEVEL_BITS = 20,
   parameter int TICK_BITS  = 32
) (
   input  logic                  sample,
   input  logic                  high_present,
   input  logic                  low_present,
   input  logic                  high_stab,
   input  logic                  low_stab,
   input  logic [LEVEL_BITS-1:0] oxygen_high,
   input  logic [LEVEL_BITS-1:0] oxygen_low,
   input  logic [LEVEL_BITS-1:0] high_min_level,
   input  logic [LEVEL_BITS-1:0] high_max_level,
   input  logic [LEVEL_BITS-1:0] low_min_level,
   input  logic [LEVEL_BITS-1:0] low_trans_level,
   input  logic [TICK_BITS-1:0]  high_since_on,
   input  logic [TICK_BITS-1:0]  low_since_on,
   output logic [LEVEL_BITS-1:0] combined_oxygen,
   output logic                  combined_valid,
   output logic                  combined_source
);

   logic [LEVEL_BITS-1:0] oh;
   logic                  src;

   assign oh = (oxygen_high < high_min_level) ? high_min_level : oxygen_high;

   always_comb begin
      if (!high_present) begin
         src = 1'b1;
      end else if (!low_present) begin
         src = 1'b0;
      end else if (!high_stab) begin
         src = 1'b1;
      end else if (!low_stab) begin
         src = 1'b0;
      end else if (oxygen_low < low_trans_level && oxygen_low > low_min_level) begin
         src = 1'b1;
      end else if (oh < high_max_level && oh > high_min_level) begin
         src = 1'b0;
      end else begin
         src = low_since_on > high_since_on;
      end
   end

   always_comb begin
      combined_valid  = sample && (high_present || low_present);
      combined_source = combined_valid && src;
      if (!combined_valid) begin
         combined_oxygen = '0;
      end else if (src) begin
         combined_oxygen = oxygen_low;
      end else begin
         combined_oxygen = oh;
      end
   end

endmodule

### sv/dual_range_oxygen_sensor_selector_core.sv
// top level of the dual range oxygen sensor selector: registers, state, handshake
// depends on drs_pkg, drs_sensor and drs_select
//
//   channel | direction | handshake           | contents
//   req_    | in        | req_valid/req_ready | mode, select, tick, readings, presence
//   rsp_    | out       | rsp_valid/rsp_ready | combined reading and sensor state
//   csr_    | in        | csr_we              | index and data, no read-back
//
// one word per cycle while rsp_ready holds; the rate is set by the sensor state loop
// an accepted word passes the input register, then the result register sets rsp_valid
// a stalled rsp_ holds the input register, which then stalls req_
// reset loads the register defaults and the sensor state and clears both valid flags
module dual_range_oxygen_sensor_selector_core #(
   parameter int LEVEL_BITS = 20,
   parameter int TICK_BITS  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_mode,
   input  logic                          req_sensor_select,
   input  logic [TICK_BITS-1:0]          req_now_ms,
   input  logic [LEVEL_BITS-1:0]         req_oxygen_high,
   input  logic [LEVEL_BITS-1:0]         req_oxygen_low,
   input  logic [drs_pkg::ADC_BITS-1:0]  req_adc_high,
   input  logic [drs_pkg::ADC_BITS-1:0]  req_adc_low,
   input  logic                          req_high_present,
   input  logic                          req_low_present,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [LEVEL_BITS-1:0]         rsp_combined_oxygen,
   output logic                          rsp_combined_valid,
   output logic                          rsp_combined_source,
   output logic [1:0]                    rsp_high_range_state,
   output logic [1:0]                    rsp_low_range_state,
   output logic                          rsp_high_in_transition,
   output logic                          rsp_low_in_transition,
   output logic                          rsp_high_stabilised,
   output logic                          rsp_low_stabilised,
   input  logic                          csr_we,
   input  logic [2:0]                    csr_index,
   input  logic [drs_pkg::CSR_BITS-1:0]  csr_wdata
);

   // configuration
   logic [LEVEL_BITS-1:0]          low_min_ff, low_max_ff, low_trans_ff;
   logic [LEVEL_BITS-1:0]          high_min_ff, high_max_ff, high_trans_ff;
   logic [drs_pkg::STAB_BITS-1:0]  stab_ms_ff;
   logic [drs_pkg::ADC_BITS-1:0]   adc_off_ff;

   // input register
   logic                           in_valid_ff;
   logic [1:0]                     mode_ff;
   logic                           sel_ff;
   logic [TICK_BITS-1:0]           now_ff;
   logic [LEVEL_BITS-1:0]          oh_ff, ol_ff;
   logic [drs_pkg::ADC_BITS-1:0]   ah_ff, al_ff;
   logic                           hp_ff, lp_ff;

   // sensor state
   drs_pkg::sensor_state_type      high_st_ff, low_st_ff, high_st_in, low_st_in;
   logic [TICK_BITS-1:0]           high_on_ff, low_on_ff, high_on_in, low_on_in;
   logic [TICK_BITS-1:0]           high_since, low_since;

   // result register
   logic                           out_valid_ff;
   logic [LEVEL_BITS-1:0]          comb_ff, comb_in;
   logic                           cvalid_ff, cvalid_in, csrc_ff, csrc_in;
   drs_pkg::sensor_state_type      high_out_ff, low_out_ff;

   logic                           advance;
   logic                           is_on;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign is_on     = (mode_ff == drs_pkg::MODE_ON);

   assign high_since = now_ff - high_on_ff;
   assign low_since  = now_ff - low_on_ff;
   assign high_on_in = (is_on && !sel_ff) ? now_ff : high_on_ff;
   assign low_on_in  = (is_on && sel_ff) ? now_ff : low_on_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_min_ff    <= '0;
         low_max_ff    <= LEVEL_BITS'(20000);
         low_trans_ff  <= LEVEL_BITS'(10000);
         high_min_ff   <= LEVEL_BITS'(10000);
         high_max_ff   <= LEVEL_BITS'(1000000);
         high_trans_ff <= LEVEL_BITS'(20000);
         stab_ms_ff    <= drs_pkg::STAB_BITS'(60000);
         adc_off_ff    <= '1;
      end else if (csr_we) begin
         case (drs_pkg::reg_index_type'(csr_index))
            drs_pkg::REG_LOW_MIN:   low_min_ff    <= csr_wdata[LEVEL_BITS-1:0];
            drs_pkg::REG_LOW_MAX:   low_max_ff    <= csr_wdata[LEVEL_BITS-1:0];
            drs_pkg::REG_LOW_TRANS: low_trans_ff  <= csr_wdata[LEVEL_BITS-1:0];
            drs_pkg::REG_HIGH_MIN:  high_min_ff   <= csr_wdata[LEVEL_BITS-1:0];
            drs_pkg::REG_HIGH_MAX:  high_max_ff   <= csr_wdata[LEVEL_BITS-1:0];
            drs_pkg::REG_HIGH_TRAN: high_trans_ff <= csr_wdata[LEVEL_BITS-1:0];
            drs_pkg::REG_STAB_MS:   stab_ms_ff    <= csr_wdata[drs_pkg::STAB_BITS-1:0];
            drs_pkg::REG_ADC_OFF:   adc_off_ff    <= csr_wdata[drs_pkg::ADC_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff <= req_mode;
         sel_ff  <= req_sensor_select;
         now_ff  <= req_now_ms;
         oh_ff   <= req_oxygen_high;
         ol_ff   <= req_oxygen_low;
         ah_ff   <= req_adc_high;
         al_ff   <= req_adc_low;
         hp_ff   <= req_high_present;
         lp_ff   <= req_low_present;
      end
   end

   drs_sensor #(.LEVEL_BITS(LEVEL_BITS), .TICK_BITS(TICK_BITS)) u_high (
      .low_side      (1'b0),
      .mode          (mode_ff),
      .selected      (!sel_ff),
      .present       (hp_ff),
      .cur           (high_st_ff),
      .since_on      (high_since),
      .lvl           (oh_ff),
      .adc           (ah_ff),
      .min_level     (high_min_ff),
      .max_level     (high_max_ff),
      .trans_level   (high_trans_ff),
      .stabilize_ms  (stab_ms_ff),
      .adc_off_level (adc_off_ff),
      .nxt           (high_st_in)
   );

   drs_sensor #(.LEVEL_BITS(LEVEL_BITS), .TICK_BITS(TICK_BITS)) u_low (
      .low_side      (1'b1),
      .mode          (mode_ff),
      .selected      (sel_ff),
      .present       (lp_ff),
      .cur           (low_st_ff),
      .since_on      (low_since),
      .lvl           (ol_ff),
      .adc           (al_ff),
      .min_level     (low_min_ff),
      .max_level     (low_max_ff),
      .trans_level   (low_trans_ff),
      .stabilize_ms  (stab_ms_ff),
      .adc_off_level (adc_off_ff),
      .nxt           (low_st_in)
   );

   drs_select #(.LEVEL_BITS(LEVEL_BITS), .TICK_BITS(TICK_BITS)) u_select (
      .sample               (mode_ff == drs_pkg::MODE_SAMPLE),
      .high_present         (hp_ff),
      .low_present          (lp_ff),
      .high_stab            (high_st_in.stab),
      .low_stab             (low_st_in.stab),
      .oxygen_high          (oh_ff),
      .oxygen_low           (ol_ff),
      .high_min_level       (high_min_ff),
      .high_max_level       (high_max_ff),
      .low_min_level        (low_min_ff),
      .low_trans_level      (low_trans_ff),
      .high_since_on        (high_since),
      .low_since_on         (low_since),
      .combined_oxygen      (comb_in),
      .combined_valid       (cvalid_in),
      .combined_source      (csrc_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         high_st_ff <= '{rs: drs_pkg::RS_WITHIN, stab: 1'b0, trans: 1'b0};
         low_st_ff  <= '{rs: drs_pkg::RS_ABOVE, stab: 1'b0, trans: 1'b0};
         high_on_ff <= '0;
         low_on_ff  <= '0;
      end else if (advance) begin
         high_st_ff <= high_st_in;
         low_st_ff  <= low_st_in;
         high_on_ff <= high_on_in;
         low_on_ff  <= low_on_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         comb_ff     <= comb_in;
         cvalid_ff   <= cvalid_in;
         csrc_ff     <= csrc_in;
         high_out_ff <= high_st_in;
         low_out_ff  <= low_st_in;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_combined_oxygen    = comb_ff;
   assign rsp_combined_valid     = cvalid_ff;
   assign rsp_combined_source    = csrc_ff;
   assign rsp_high_range_state   = high_out_ff.rs;
   assign rsp_low_range_state    = low_out_ff.rs;
   assign rsp_high_in_transition = high_out_ff.trans;
   assign rsp_low_in_transition  = low_out_ff.trans;
   assign rsp_high_stabilised    = high_out_ff.stab;
   assign rsp_low_stabilised     = low_out_ff.stab;

   // no selection without a reading
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_combined_valid) |->
         (rsp_combined_oxygen == '0 && !rsp_combined_source))
      else $error("combined fields set without a valid reading");

   // sensor state moves only when a word goes through
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(high_st_ff) && $stable(low_st_ff) &&
                    $stable(high_on_ff) && $stable(low_on_ff)))
      else $error("sensor state changed without a word");

   // a held input word keeps its contents
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(mode_ff) &&
                                     $stable(now_ff) && $stable(sel_ff)))
      else $error("input register lost a stalled word");

endmodule

### tb/oxygen_check_pkg.sv
// word types and the scoreboard for the dual range oxygen sensor selector bench
// depends on drs_pkg; the scoreboard predicts each reading from the accepted request words
package oxygen_check_pkg;
   import drs_pkg::*;

   localparam int LEVEL_W = 20;
   localparam int TICK_W = 32;
   localparam int REPORT_LIMIT = 100;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]          mode;
      logic                sensor_select;
      logic [TICK_W-1:0]   now_ms;
      logic [LEVEL_W-1:0]  oxygen_high;
      logic [LEVEL_W-1:0]  oxygen_low;
      logic [ADC_BITS-1:0] adc_high;
      logic [ADC_BITS-1:0] adc_low;
      logic                high_present;
      logic                low_present;
   } request_t;

   typedef struct packed {
      logic [LEVEL_W-1:0] combined_oxygen;
      logic               combined_valid;
      logic               combined_source;
      range_type          high_range_state;
      range_type          low_range_state;
      logic               high_in_transition;
      logic               low_in_transition;
      logic               high_stabilised;
      logic               low_stabilised;
   } reading_t;

   class selector_scoreboard;
      logic [LEVEL_W-1:0]  low_min, low_max, low_trans;
      logic [LEVEL_W-1:0]  high_min, high_max, high_trans;
      logic [TICK_W-1:0]   stab_ms;
      logic [ADC_BITS-1:0] adc_off;
      range_type           sensor_range [2];
      logic                settled [2];
      logic                in_trans [2];
      logic [TICK_W-1:0]   turned_on [2];
      reading_t            expected_readings [$];
      int                  errors;

      function new();
         low_min = '0;
         low_max = 20'd20000;
         low_trans = 20'd10000;
         high_min = 20'd10000;
         high_max = 20'd1000000;
         high_trans = 20'd20000;
         stab_ms = 32'd60000;
         adc_off = 16'hFFFF;
         sensor_range[0] = RS_WITHIN;
         sensor_range[1] = RS_ABOVE;
         for (int s = 0; s < 2; s++) begin
            settled[s] = 1'b0;
            in_trans[s] = 1'b0;
            turned_on[s] = '0;
         end
         errors = 0;
      endfunction

      function void set_register(reg_index_type idx, logic [CSR_BITS-1:0] v);
         case (idx)
            REG_LOW_MIN:   low_min = v[LEVEL_W-1:0];
            REG_LOW_MAX:   low_max = v[LEVEL_W-1:0];
            REG_LOW_TRANS: low_trans = v[LEVEL_W-1:0];
            REG_HIGH_MIN:  high_min = v[LEVEL_W-1:0];
            REG_HIGH_MAX:  high_max = v[LEVEL_W-1:0];
            REG_HIGH_TRAN: high_trans = v[LEVEL_W-1:0];
            REG_STAB_MS:   stab_ms = v[TICK_W-1:0];
            REG_ADC_OFF:   adc_off = v[ADC_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [TICK_W-1:0] elapsed(int s, logic [TICK_W-1:0] now);
         return now - turned_on[s];
      endfunction

      // s is 0 for the high range sensor, 1 for the low range sensor
      function void classify(int s, logic [LEVEL_W-1:0] lvl, logic [ADC_BITS-1:0] adc,
                             logic [TICK_W-1:0] now);
         logic [LEVEL_W-1:0] lo_lim;
         logic [LEVEL_W-1:0] hi_lim;
         lo_lim = (s == 1) ? low_min : high_min;
         hi_lim = (s == 1) ? low_max : high_max;
         if (!settled[s]) begin
            if (elapsed(s, now) > stab_ms)
               settled[s] = 1'b1;
            return;
         end
         if (lvl > hi_lim || adc >= adc_off) begin
            sensor_range[s] = RS_ABOVE;
            in_trans[s] = (s == 1);
         end else if (lvl < lo_lim) begin
            sensor_range[s] = RS_BELOW;
            in_trans[s] = (s == 0);
         end else if ((s == 1 && lvl > low_trans) || (s == 0 && lvl < high_trans)) begin
            in_trans[s] = 1'b1;
         end else if (lvl > lo_lim && lvl < hi_lim) begin
            sensor_range[s] = RS_WITHIN;
            in_trans[s] = 1'b0;
         end
      endfunction

      function void note_request(request_t w);
         reading_t           r;
         logic [LEVEL_W-1:0] oh;
         logic [LEVEL_W-1:0] ol;
         logic               src;
         r = '0;
         oh = w.oxygen_high;
         ol = w.oxygen_low;
         src = 1'b0;
         case (w.mode)
            MODE_ON: begin
               sensor_range[w.sensor_select] = RS_WITHIN;
               settled[w.sensor_select] = 1'b0;
               turned_on[w.sensor_select] = w.now_ms;
            end
            MODE_OFF: begin
               settled[w.sensor_select] = 1'b0;
               in_trans[w.sensor_select] = 1'b0;
            end
            MODE_SAMPLE: begin
               if (w.high_present)
                  classify(0, w.oxygen_high, w.adc_high, w.now_ms);
               if (w.low_present)
                  classify(1, w.oxygen_low, w.adc_low, w.now_ms);
               if (w.high_present && oh < high_min)
                  oh = high_min;
               if (w.high_present || w.low_present) begin
                  if (!w.high_present)
                     src = 1'b1;
                  else if (!w.low_present)
                     src = 1'b0;
                  else if (!settled[0])
                     src = 1'b1;
                  else if (!settled[1])
                     src = 1'b0;
                  else if (ol < low_trans && ol > low_min)
                     src = 1'b1;
                  else if (oh < high_max && oh > high_min)
                     src = 1'b0;
                  else
                     src = elapsed(1, w.now_ms) > elapsed(0, w.now_ms);
                  r.combined_valid = 1'b1;
                  r.combined_source = src;
                  r.combined_oxygen = src ? ol : oh;
               end
            end
            default: ;
         endcase
         r.high_range_state = sensor_range[0];
         r.low_range_state = sensor_range[1];
         r.high_in_transition = in_trans[0];
         r.low_in_transition = in_trans[1];
         r.high_stabilised = settled[0];
         r.low_stabilised = settled[1];
         expected_readings.push_back(r);
      endfunction

      function void compare(string field, longint unsigned want, longint unsigned got);
         if (want != got) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_reading(reading_t got);
         reading_t want;
         if (expected_readings.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: unexpected word, expected none actual combined %0d",
                        $time, got.combined_oxygen);
            return;
         end
         want = expected_readings.pop_front();
         compare("combined_oxygen", want.combined_oxygen, got.combined_oxygen);
         compare("combined_valid", want.combined_valid, got.combined_valid);
         compare("combined_source", want.combined_source, got.combined_source);
         compare("high_range_state", want.high_range_state, got.high_range_state);
         compare("low_range_state", want.low_range_state, got.low_range_state);
         compare("high_in_transition", want.high_in_transition, got.high_in_transition);
         compare("low_in_transition", want.low_in_transition, got.low_in_transition);
         compare("high_stabilised", want.high_stabilised, got.high_stabilised);
         compare("low_stabilised", want.low_stabilised, got.low_stabilised);
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction
   endclass

endpackage

### tb/tb.sv
// bench top for dual_range_oxygen_sensor_selector_core: directed and random request words
// under random stalls on both channels, several register settings; depends on drs_pkg
// and oxygen_check_pkg
module tb;
   import drs_pkg::*;
   import oxygen_check_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 180;
   localparam int PHASES = 6;
   localparam int HOLD_CYCLES = 200;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_mode;
   logic                 req_sensor_select;
   logic [TICK_W-1:0]    req_now_ms;
   logic [LEVEL_W-1:0]   req_oxygen_high;
   logic [LEVEL_W-1:0]   req_oxygen_low;
   logic [ADC_BITS-1:0]  req_adc_high;
   logic [ADC_BITS-1:0]  req_adc_low;
   logic                 req_high_present;
   logic                 req_low_present;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [LEVEL_W-1:0]   rsp_combined_oxygen;
   logic                 rsp_combined_valid;
   logic                 rsp_combined_source;
   logic [1:0]           rsp_high_range_state;
   logic [1:0]           rsp_low_range_state;
   logic                 rsp_high_in_transition;
   logic                 rsp_low_in_transition;
   logic                 rsp_high_stabilised;
   logic                 rsp_low_stabilised;
   logic                 csr_we;
   logic [2:0]           csr_index;
   logic [CSR_BITS-1:0]  csr_wdata;

   selector_scoreboard   sb;
   bit                   steady;
   bit                   hold_req;
   logic [TICK_W-1:0]    tick;
   logic [TICK_W-1:0]    step_max;
   int                   cycles = 0;

   dual_range_oxygen_sensor_selector_core u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_mode               (req_mode),
      .req_sensor_select      (req_sensor_select),
      .req_now_ms             (req_now_ms),
      .req_oxygen_high        (req_oxygen_high),
      .req_oxygen_low         (req_oxygen_low),
      .req_adc_high           (req_adc_high),
      .req_adc_low            (req_adc_low),
      .req_high_present       (req_high_present),
      .req_low_present        (req_low_present),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_combined_oxygen    (rsp_combined_oxygen),
      .rsp_combined_valid     (rsp_combined_valid),
      .rsp_combined_source    (rsp_combined_source),
      .rsp_high_range_state   (rsp_high_range_state),
      .rsp_low_range_state    (rsp_low_range_state),
      .rsp_high_in_transition (rsp_high_in_transition),
      .rsp_low_in_transition  (rsp_low_in_transition),
      .rsp_high_stabilised    (rsp_high_stabilised),
      .rsp_low_stabilised     (rsp_low_stabilised),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin : watch_ports
      reading_t seen;
      request_t taken;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen.combined_oxygen = rsp_combined_oxygen;
            seen.combined_valid = rsp_combined_valid;
            seen.combined_source = rsp_combined_source;
            seen.high_range_state = range_type'(rsp_high_range_state);
            seen.low_range_state = range_type'(rsp_low_range_state);
            seen.high_in_transition = rsp_high_in_transition;
            seen.low_in_transition = rsp_low_in_transition;
            seen.high_stabilised = rsp_high_stabilised;
            seen.low_stabilised = rsp_low_stabilised;
            sb.check_reading(seen);
         end
         if (req_valid && req_ready) begin
            taken.mode = req_mode;
            taken.sensor_select = req_sensor_select;
            taken.now_ms = req_now_ms;
            taken.oxygen_high = req_oxygen_high;
            taken.oxygen_low = req_oxygen_low;
            taken.adc_high = req_adc_high;
            taken.adc_low = req_adc_low;
            taken.high_present = req_high_present;
            taken.low_present = req_low_present;
            sb.note_request(taken);
         end
      end
   end

   // result side: random stalls, or a long hold-off on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 12);
         end
      end
   end

   function automatic request_t word(logic [1:0] mode, logic sel, logic [TICK_W-1:0] now,
                                     logic [LEVEL_W-1:0] oh, logic [LEVEL_W-1:0] ol,
                                     logic [ADC_BITS-1:0] ah, logic [ADC_BITS-1:0] al,
                                     logic hp, logic lp);
      request_t w;
      w.mode = mode;
      w.sensor_select = sel;
      w.now_ms = now;
      w.oxygen_high = oh;
      w.oxygen_low = ol;
      w.adc_high = ah;
      w.adc_low = al;
      w.high_present = hp;
      w.low_present = lp;
      return w;
   endfunction

   function automatic logic [LEVEL_W-1:0] pick_level(logic [LEVEL_W-1:0] lo,
                                                     logic [LEVEL_W-1:0] mid,
                                                     logic [LEVEL_W-1:0] hi);
      logic [LEVEL_W-1:0] edges [3];
      edges[0] = lo;
      edges[1] = mid;
      edges[2] = hi;
      case ($urandom_range(9))
         0, 1, 2, 3: return edges[$urandom_range(2)] + LEVEL_W'($urandom_range(2)) - 1'b1;
         4: return '0;
         5: return '1;
         6, 7: return LEVEL_W'($urandom_range(lo, hi));
         default: return LEVEL_W'($urandom);
      endcase
   endfunction

   function automatic logic [ADC_BITS-1:0] pick_adc();
      case ($urandom_range(9))
         0: return sb.adc_off - 1'b1;
         1: return sb.adc_off;
         2: return '1;
         3: return '0;
         default: return ADC_BITS'($urandom);
      endcase
   endfunction

   function automatic request_t random_request();
      request_t w;
      int       pick;
      pick = $urandom_range(99);
      if ($urandom_range(99) < 3)
         tick = $urandom;
      else
         tick = tick + $urandom_range(0, step_max);
      w.mode = (pick < 82) ? MODE_SAMPLE : (pick < 92) ? MODE_ON : MODE_OFF;
      w.sensor_select = 1'($urandom_range(1));
      w.now_ms = tick;
      w.oxygen_high = pick_level(sb.high_min, sb.high_trans, sb.high_max);
      w.oxygen_low = pick_level(sb.low_min, sb.low_trans, sb.low_max);
      w.adc_high = pick_adc();
      w.adc_low = pick_adc();
      w.high_present = $urandom_range(99) < 85;
      w.low_present = $urandom_range(99) < 85;
      return w;
   endfunction

   task automatic offer(request_t w);
      if (!steady && $urandom_range(99) < 4) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= w.mode;
      req_sensor_select <= w.sensor_select;
      req_now_ms <= w.now_ms;
      req_oxygen_high <= w.oxygen_high;
      req_oxygen_low <= w.oxygen_low;
      req_adc_high <= w.adc_high;
      req_adc_low <= w.adc_low;
      req_high_present <= w.high_present;
      req_low_present <= w.low_present;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(int phase);
      logic [CSR_BITS-1:0] v [8];
      case (phase)
         1: begin
            v[REG_LOW_MIN] = 100;
            v[REG_LOW_MAX] = 20000;
            v[REG_LOW_TRANS] = 10000;
            v[REG_HIGH_MIN] = 10000;
            v[REG_HIGH_MAX] = 1000000;
            v[REG_HIGH_TRAN] = 20000;
            v[REG_STAB_MS] = 200;
            v[REG_ADC_OFF] = 60000;
         end
         2: begin
            foreach (v[i]) v[i] = '0;
         end
         3: begin
            foreach (v[i]) v[i] = 32'h000F_FFFF;
            v[REG_STAB_MS] = 32'hFFFF_FFFF;
            v[REG_ADC_OFF] = 32'h0000_FFFF;
         end
         4: begin
            foreach (v[i]) v[i] = $urandom_range(0, 32'h000F_FFFF);
            v[REG_STAB_MS] = $urandom_range(0, 1000);
            v[REG_ADC_OFF] = $urandom_range(0, 32'h0000_FFFF);
         end
         default: begin
            v[REG_LOW_MIN] = $urandom_range(0, 5000);
            v[REG_LOW_TRANS] = v[REG_LOW_MIN] + $urandom_range(0, 10000);
            v[REG_LOW_MAX] = v[REG_LOW_TRANS] + $urandom_range(0, 10000);
            v[REG_HIGH_MIN] = $urandom_range(0, 20000);
            v[REG_HIGH_TRAN] = v[REG_HIGH_MIN] + $urandom_range(0, 30000);
            v[REG_HIGH_MAX] = v[REG_HIGH_TRAN] + $urandom_range(0, 900000);
            v[REG_STAB_MS] = $urandom_range(0, 50);
            v[REG_ADC_OFF] = $urandom_range(30000, 32'h0000_FFFF);
         end
      endcase
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= reg_index_type'(i);
         csr_wdata <= v[i];
         @(posedge clock);
         sb.set_register(reg_index_type'(i), v[i]);
      end
      csr_we <= 1'b0;
   endtask

   // runs on the reset register values
   task automatic directed();
      offer(word(MODE_SAMPLE, 1'b1, 32'hFFFF_FFFF, '1, '1, '1, '1, 1'b0, 1'b0));
      offer(word(MODE_SAMPLE, 1'b0, 32'd5, '0, '0, '0, '0, 1'b1, 1'b0));
      offer(word(MODE_SAMPLE, 1'b0, 32'd6, '1, '1, '1, '1, 1'b0, 1'b1));
      offer(word(MODE_UNUSED, 1'b1, 32'd7, '1, '1, '1, '1, 1'b1, 1'b1));
      offer(word(MODE_ON, 1'b0, 32'd100, '0, '0, '0, '0, 1'b0, 1'b0));
      offer(word(MODE_ON, 1'b1, 32'd100, '0, '0, '0, '0, 1'b0, 1'b0));
      // settle time reached but not exceeded, then exceeded by one
      offer(word(MODE_SAMPLE, 1'b0, 32'd60100, 20'd500000, 20'd5000, 16'd100, 16'd100,
                 1'b1, 1'b1));
      offer(word(MODE_SAMPLE, 1'b0, 32'd60101, 20'd500000, 20'd5000, 16'd100, 16'd100,
                 1'b1, 1'b1));
      // both out of working range with equal on time
      offer(word(MODE_SAMPLE, 1'b0, 32'd60102, '0, '0, '0, '0, 1'b1, 1'b1));
      offer(word(MODE_SAMPLE, 1'b0, 32'd60103, 20'd1000000, 20'd15000, '1, '0, 1'b1, 1'b1));
      offer(word(MODE_SAMPLE, 1'b0, 32'hFFFF_FFFF, 20'd500000, 20'd5000, 16'd100, 16'd100,
                 1'b1, 1'b1));
      offer(word(MODE_SAMPLE, 1'b0, 32'd60104, 20'd15000, 20'd20001, 16'd100, 16'd100,
                 1'b1, 1'b1));
      offer(word(MODE_ON, 1'b1, 32'd200, '0, '0, '0, '0, 1'b0, 1'b0));
      offer(word(MODE_SAMPLE, 1'b0, 32'd200, '0, '0, '0, '0, 1'b0, 1'b1));
      offer(word(MODE_OFF, 1'b0, 32'd300, '0, '0, '0, '0, 1'b0, 1'b0));
      offer(word(MODE_SAMPLE, 1'b0, 32'd60500, 20'd500000, 20'd5000, 16'd100, 16'd100,
                 1'b1, 1'b1));
      offer(word(MODE_ON, 1'b0, 32'd400, '0, '0, '0, '0, 1'b0, 1'b0));
      offer(word(MODE_SAMPLE, 1'b0, 32'd61000, 20'd500000, 20'd5000, 16'd100, 16'd100,
                 1'b1, 1'b1));
      // low sensor on longer wins the tie break
      offer(word(MODE_SAMPLE, 1'b0, 32'd61000, 20'd5, '0, '0, '0, 1'b1, 1'b1));
      offer(word(MODE_OFF, 1'b1, 32'd61001, '0, '0, '0, '0, 1'b0, 1'b0));
      offer(word(MODE_SAMPLE, 1'b0, 32'hFFFF_FFFF, '1, '0, '0, '1, 1'b1, 1'b1));
   endtask

   initial begin
      sb = new();
      steady = 1'b0;
      hold_req = 1'b0;
      tick = '0;
      step_max = '0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= MODE_SAMPLE;
      req_sensor_select <= 1'b0;
      req_now_ms <= '0;
      req_oxygen_high <= '0;
      req_oxygen_low <= '0;
      req_adc_high <= '0;
      req_adc_low <= '0;
      req_high_present <= 1'b0;
      req_low_present <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= REG_LOW_MIN;
      csr_wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      directed();
      tick = 32'd70000;
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            drain();
            configure(phase);
         end
         step_max = (sb.stab_ms > 32'h1000_0000) ? 32'h0400_0000 : (sb.stab_ms >> 2) + 32'd2;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            steady = (phase == 2 && n >= 40 && n < 140);
            if (phase == 1 && n == 50)
               hold_req = 1'b1;
            if (phase == 3 && n == 90)
               drain();
            offer(random_request());
         end
      end
      steady = 1'b0;
      drain();
      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### sim.f
sv/drs_pkg.sv
sv/drs_sensor.sv
sv/drs_select.sv
sv/dual_range_oxygen_sensor_selector_core.sv
tb/oxygen_check_pkg.sv
tb/tb.sv
